// ----- rtl/core/gaze_to_dac_code_mapper_defines.svh -----
// Assertion macros for the gaze to DAC code mapper.
`ifndef GAZE_TO_DAC_CODE_MAPPER_DEFINES_SVH
`define GAZE_TO_DAC_CODE_MAPPER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define G2D_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define G2D_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/g2dac_pkg.sv -----
// Types, constants and helpers shared by the gaze to DAC code mapper.
package g2dac_pkg;

    localparam int NUM_W = 26;
    localparam int LIM_W = 22;
    localparam int T_W   = 23;
    localparam int CODE_W = 16;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int OPEN_LIMIT = 512;

    typedef enum logic [1:0] {
        GM_PIXEL    = 2'd0,
        GM_CAMERA   = 2'd1,
        GM_OBJECT   = 2'd2,
        GM_RESERVED = 2'd3
    } gaze_mode_t;

    typedef enum logic [1:0] {
        FM_MAX  = 2'd0,
        FM_MID  = 2'd1,
        FM_MIN  = 2'd2,
        FM_HOLD = 2'd3
    } fail_mode_t;

    typedef enum logic [2:0] {
        REG_GAZE_MODE  = 3'd0,
        REG_CENTER_H   = 3'd1,
        REG_CENTER_V   = 3'd2,
        REG_GAZE_AMP   = 3'd3,
        REG_PUPIL_OFS  = 3'd4,
        REG_PUPIL_AMP  = 3'd5,
        REG_HALF_RANGE = 3'd6,
        REG_FAIL_MODE  = 3'd7
    } reg_index_t;

    // clamp n to [-lim, lim] and shift into [0, 2*lim]
    function automatic logic [T_W-1:0] volt_offset(input logic signed [NUM_W-1:0] n,
                                                   input logic [LIM_W-1:0] lim);
        logic signed [NUM_W-1:0] ls;
        logic signed [NUM_W-1:0] c;
        logic signed [NUM_W-1:0] s;
        ls = $signed(NUM_W'(lim));
        if (n > ls) begin
            c = ls;
        end else if (n < -ls) begin
            c = -ls;
        end else begin
            c = n;
        end
        s = c + ls;
        return s[T_W-1:0];
    endfunction

endpackage

// ----- rtl/core/gaze_to_dac_code_mapper.sv -----
// Gaze to DAC code mapper: eye-tracker sample in, four DAC codes out.
//
// Input channel s_*: one sample per item (valid/ready). Result channel m_*:
// horizontal, vertical, pupil and eyelid codes, DAC_BITS wide, zero extended.
// Configuration must be written over the APB-style port only while no item is
// in flight; the block does not enforce it. Each gaze and pupil voltage is
// clamped to +/-10 V and scaled by a restoring divider that resolves one
// quotient bit per register stage. There are DAC_BITS + 4 register stages
// (three front stages, DAC_BITS divider stages, one output register); the
// first loads at the accept edge, and m_valid rises as the item reaches the
// output register. Throughput is one item per cycle while the receiver takes
// results; the whole pipeline advances together. A sample that yields no
// result (invalid with hold, or undefined gaze mode) is accepted and dropped
// at entry. When the receiver stalls with a result waiting, the pipeline
// freezes and s_ready drops; nothing is lost or repeated. Reset (aresetn low,
// synchronous) empties the pipeline and loads the register defaults.
module gaze_to_dac_code_mapper
    import g2dac_pkg::*;
#(
    parameter int DAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_sample_valid,
    input  logic signed [15:0]       s_gaze_x,
    input  logic signed [15:0]       s_gaze_y,
    input  logic [15:0]              s_pupil_size,
    input  logic [9:0]               s_open_ratio,
    input  logic [11:0]              s_image_width,
    input  logic [11:0]              s_image_height,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CODE_W-1:0]        m_code_h,
    output logic [CODE_W-1:0]        m_code_v,
    output logic [CODE_W-1:0]        m_code_pupil,
    output logic [CODE_W-1:0]        m_code_open
);

`include "gaze_to_dac_code_mapper_defines.svh"

    localparam int B  = DAC_BITS;
    localparam int NW = T_W + DAC_BITS;
    localparam logic [DAC_BITS-1:0] CODE_MAX  = '1;
    localparam logic [DAC_BITS-1:0] CODE_MID  = DAC_BITS'((2 ** (DAC_BITS - 1)) - 1);
    localparam logic [DAC_BITS-1:0] HALF_BIAS = DAC_BITS'((2 ** (DAC_BITS - 2)) - 1);

    // configuration
    logic [1:0]         gaze_mode_reg;
    logic signed [10:0] center_h_reg;
    logic signed [10:0] center_v_reg;
    logic [6:0]         gaze_amp_reg;
    logic signed [7:0]  pupil_ofs_reg;
    logic [6:0]         pupil_amp_reg;
    logic               half_range_reg;
    logic [1:0]         fail_mode_reg;
    logic               cfg_wr;
    reg_index_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gaze_mode_reg  <= GM_PIXEL;
            center_h_reg   <= 11'sd500;
            center_v_reg   <= 11'sd500;
            gaze_amp_reg   <= 7'd10;
            pupil_ofs_reg  <= 8'sd0;
            pupil_amp_reg  <= 7'd10;
            half_range_reg <= 1'b0;
            fail_mode_reg  <= FM_HOLD;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GAZE_MODE:  gaze_mode_reg  <= pwdata[1:0];
                REG_CENTER_H:   center_h_reg   <= $signed(pwdata[10:0]);
                REG_CENTER_V:   center_v_reg   <= $signed(pwdata[10:0]);
                REG_GAZE_AMP:   gaze_amp_reg   <= pwdata[6:0];
                REG_PUPIL_OFS:  pupil_ofs_reg  <= $signed(pwdata[7:0]);
                REG_PUPIL_AMP:  pupil_amp_reg  <= pwdata[6:0];
                REG_HALF_RANGE: half_range_reg <= pwdata[0];
                REG_FAIL_MODE:  fail_mode_reg  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GAZE_MODE:  prdata = DATA_W'(gaze_mode_reg);
            REG_CENTER_H:   prdata = DATA_W'(center_h_reg);
            REG_CENTER_V:   prdata = DATA_W'(center_v_reg);
            REG_GAZE_AMP:   prdata = DATA_W'(gaze_amp_reg);
            REG_PUPIL_OFS:  prdata = DATA_W'(pupil_ofs_reg);
            REG_PUPIL_AMP:  prdata = DATA_W'(pupil_amp_reg);
            REG_HALF_RANGE: prdata = DATA_W'(half_range_reg);
            REG_FAIL_MODE:  prdata = DATA_W'(fail_mode_reg);
            default:        prdata = '0;
        endcase
    end

    // pipeline control
    logic en;
    logic push;
    logic m_valid_reg;
    logic pixel_mode;
    logic [6:0] ga;
    logic [6:0] pa;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign push    = s_valid && (s_sample_valid ? (gaze_mode_reg != GM_RESERVED)
                                                : (fail_mode_reg != FM_HOLD));
    assign pixel_mode = (gaze_mode_reg == GM_PIXEL);
    assign ga = (gaze_amp_reg == 7'd0) ? 7'd1 : gaze_amp_reg;
    assign pa = (pupil_amp_reg == 7'd0) ? 7'd1 : pupil_amp_reg;

    // stage 1: products and mode select
    logic                    v1_reg;
    logic                    sv1_reg;
    logic signed [NUM_W-1:0] gsc_h1_reg, gsc_v1_reg;
    logic signed [NUM_W-1:0] ctr_h1_reg, ctr_v1_reg;
    logic [17:0]             dd_g1_reg;
    logic [18:0]             ps5_1_reg;
    logic signed [15:0]      pm1_reg;
    logic [13:0]             dd_p1_reg;
    logic [B-1:0]            oc1_reg;

    logic signed [23:0]      iw_ch, ih_cv;
    logic [9:0]              om;
    logic [B+9:0]            oprod;

    assign iw_ch = $signed({1'b0, s_image_width}) * center_h_reg;
    assign ih_cv = $signed({1'b0, s_image_height}) * center_v_reg;
    assign om    = (s_open_ratio > 10'(OPEN_LIMIT)) ? 10'(OPEN_LIMIT) : s_open_ratio;
    assign oprod = (B+10)'(om) * (B+10)'(CODE_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sv1_reg <= s_sample_valid;
            if (pixel_mode) begin
                gsc_h1_reg <= NUM_W'(s_gaze_x) * NUM_W'(125);
                gsc_v1_reg <= NUM_W'(s_gaze_y) * NUM_W'(125);
                ctr_h1_reg <= NUM_W'(iw_ch) <<< 1;
                ctr_v1_reg <= NUM_W'(ih_cv) <<< 1;
                dd_g1_reg  <= 18'(ga) * 18'd2000;
            end else begin
                gsc_h1_reg <= NUM_W'(s_gaze_x) * NUM_W'(5);
                gsc_v1_reg <= NUM_W'(s_gaze_y) * NUM_W'(5);
                ctr_h1_reg <= NUM_W'(center_h_reg) <<< 3;
                ctr_v1_reg <= NUM_W'(center_v_reg) <<< 3;
                dd_g1_reg  <= 18'(ga) << 3;
            end
            ps5_1_reg <= 19'(s_pupil_size) * 19'd5;
            pm1_reg   <= $signed({1'b0, pa}) * pupil_ofs_reg;
            dd_p1_reg <= 14'(pa) * 14'd80;
            oc1_reg   <= oprod[B+9:10] + CODE_MID;
        end
    end

    // stage 2: numerator, clamp, offset
    logic                    v2_reg;
    logic                    sv2_reg;
    logic [T_W-1:0]          t_h2_reg, t_v2_reg, t_p2_reg;
    logic [T_W-1:0]          d_g2_reg, d_p2_reg;
    logic [B-1:0]            oc2_reg;
    logic [LIM_W-1:0]        lim_g, lim_p;
    logic signed [NUM_W-1:0] n_h, n_v, n_p;

    assign lim_g = LIM_W'(dd_g1_reg) * LIM_W'(10);
    assign lim_p = LIM_W'(dd_p1_reg) * LIM_W'(10);
    assign n_h   = gsc_h1_reg - ctr_h1_reg;
    assign n_v   = gsc_v1_reg - ctr_v1_reg;
    assign n_p   = $signed(NUM_W'(ps5_1_reg)) + (NUM_W'(pm1_reg) <<< 3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sv2_reg  <= sv1_reg;
            t_h2_reg <= volt_offset(n_h, lim_g);
            t_v2_reg <= volt_offset(n_v, lim_g);
            t_p2_reg <= volt_offset(n_p, lim_p);
            d_g2_reg <= T_W'(lim_g) << 1;
            d_p2_reg <= T_W'(lim_p) << 1;
            oc2_reg  <= oc1_reg;
        end
    end

    // stage 3 and divider stages: index 0 is the scaled numerator
    logic          vd_reg  [0:B];
    logic          svd_reg [0:B];
    logic [NW-1:0] rem_reg [0:B][0:2];
    logic [B-1:0]  quo_reg [0:B][0:2];
    logic [T_W-1:0] dg_reg [0:B];
    logic [T_W-1:0] dp_reg [0:B];
    logic [B-1:0]  ocd_reg [0:B];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg[0] <= 1'b0;
        end else if (en) begin
            vd_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            svd_reg[0]    <= sv2_reg;
            rem_reg[0][0] <= (NW'(t_h2_reg) << B) - NW'(t_h2_reg);
            rem_reg[0][1] <= (NW'(t_v2_reg) << B) - NW'(t_v2_reg);
            rem_reg[0][2] <= (NW'(t_p2_reg) << B) - NW'(t_p2_reg);
            quo_reg[0][0] <= '0;
            quo_reg[0][1] <= '0;
            quo_reg[0][2] <= '0;
            dg_reg[0]     <= d_g2_reg;
            dp_reg[0]     <= d_p2_reg;
            ocd_reg[0]    <= oc2_reg;
        end
    end

    for (genvar j = 0; j < B; j++) begin : g_div
        localparam int K = B - 1 - j;
        logic [NW-1:0] dsh [0:2];

        assign dsh[0] = NW'(dg_reg[j]) << K;
        assign dsh[1] = NW'(dg_reg[j]) << K;
        assign dsh[2] = NW'(dp_reg[j]) << K;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[j+1] <= 1'b0;
            end else if (en) begin
                vd_reg[j+1] <= vd_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                svd_reg[j+1] <= svd_reg[j];
                dg_reg[j+1]  <= dg_reg[j];
                dp_reg[j+1]  <= dp_reg[j];
                ocd_reg[j+1] <= ocd_reg[j];
                for (int c = 0; c < 3; c++) begin
                    if (rem_reg[j][c] >= dsh[c]) begin
                        rem_reg[j+1][c] <= rem_reg[j][c] - dsh[c];
                        quo_reg[j+1][c] <= quo_reg[j][c] | (B'(1) << K);
                    end else begin
                        rem_reg[j+1][c] <= rem_reg[j][c];
                        quo_reg[j+1][c] <= quo_reg[j][c];
                    end
                end
            end
        end
    end

    // output stage: failure codes and half range
    logic [B-1:0]      raw [0:3];
    logic [B-1:0]      fin [0:3];
    logic [B-1:0]      fail_code;
    logic              halve;
    logic [CODE_W-1:0] code_h_reg, code_v_reg, code_p_reg, code_o_reg;

    always_comb begin
        case (fail_mode_reg)
            FM_MAX:  fail_code = CODE_MAX;
            FM_MID:  fail_code = CODE_MID;
            default: fail_code = '0;
        endcase
        if (svd_reg[B]) begin
            raw[0] = quo_reg[B][0];
            raw[1] = quo_reg[B][1];
            raw[2] = quo_reg[B][2];
            raw[3] = ocd_reg[B];
            halve  = half_range_reg;
        end else begin
            raw[0] = fail_code;
            raw[1] = fail_code;
            raw[2] = fail_code;
            raw[3] = fail_code;
            halve  = half_range_reg && (fail_mode_reg != FM_MID);
        end
        for (int c = 0; c < 4; c++) begin
            fin[c] = halve ? ((raw[c] >> 1) + HALF_BIAS) : raw[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vd_reg[B];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            code_h_reg <= CODE_W'(fin[0]);
            code_v_reg <= CODE_W'(fin[1]);
            code_p_reg <= CODE_W'(fin[2]);
            code_o_reg <= CODE_W'(fin[3]);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_code_h     = code_h_reg;
    assign m_code_v     = code_v_reg;
    assign m_code_pupil = code_p_reg;
    assign m_code_open  = code_o_reg;

    `G2D_ASSERT_NEXT(a_drop_hold, aclk, aresetn,
        s_valid && s_ready && !s_sample_valid && (fail_mode_reg == FM_HOLD), !v1_reg)
    `G2D_ASSERT_NEXT(a_freeze, aclk, aresetn, !en, $stable(vd_reg[0]) && $stable(v2_reg))
    `G2D_ASSERT_SAME(a_code_range, aclk, aresetn, m_valid,
        (m_code_h <= CODE_W'(CODE_MAX)) && (m_code_pupil <= CODE_W'(CODE_MAX)))

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the gaze to DAC code mapper: directed and random samples, checked in order.
module tb_top
    import g2dac_pkg::*;
;

    localparam int CMAX = 65535;
    localparam int CMID = 32767;
    localparam int HBIAS = 16383;
    localparam int LAT = 24;

    typedef struct packed {
        logic [15:0] h;
        logic [15:0] v;
        logic [15:0] p;
        logic [15:0] o;
    } codes_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 0;
    logic s_ready;
    logic s_sample_valid = 0;
    logic signed [15:0] s_gaze_x = 0, s_gaze_y = 0;
    logic [15:0] s_pupil_size = 0;
    logic [9:0] s_open_ratio = 0;
    logic [11:0] s_image_width = 0, s_image_height = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [15:0] m_code_h, m_code_v, m_code_pupil, m_code_open;

    gaze_to_dac_code_mapper dut (.*);

    logic [1:0] cfg_mode;
    logic signed [10:0] cfg_ch, cfg_cv;
    logic [6:0] cfg_gamp, cfg_pamp;
    logic signed [7:0] cfg_pofs;
    logic cfg_half;
    logic [1:0] cfg_fail;

    codes_t expected_codes[$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    bit hold_off = 0;
    bit rx_idle_off = 0;

    initial forever #5 aclk = ~aclk;

    function automatic longint volt_to_code(longint num, longint den);
        longint lim;
        lim = 10 * den;
        if (num < -lim) num = -lim;
        if (num > lim) num = lim;
        return (CMAX * (num + lim)) / (2 * lim);
    endfunction

    function automatic bit predict_codes(bit sv, longint gx, longint gy, longint ps,
                                         longint orat, longint iw, longint ih,
                                         output codes_t c);
        longint ga, pa, d, fixed;
        longint r[4];
        bit halve;
        ga = cfg_gamp == 0 ? 1 : cfg_gamp;
        pa = cfg_pamp == 0 ? 1 : cfg_pamp;
        halve = cfg_half;
        if (!sv) begin
            if (cfg_fail == FM_HOLD) return 0;
            if (cfg_fail == FM_MAX) fixed = CMAX;
            else if (cfg_fail == FM_MIN) fixed = 0;
            else begin
                fixed = CMID;
                halve = 0;
            end
            for (int i = 0; i < 4; i++) r[i] = fixed;
        end else begin
            if (cfg_mode == GM_PIXEL) begin
                d = 16000 * ga;
                r[0] = volt_to_code(1000 * gx - 16 * iw * longint'(cfg_ch), d);
                r[1] = volt_to_code(1000 * gy - 16 * ih * longint'(cfg_cv), d);
            end else if (cfg_mode == GM_CAMERA || cfg_mode == GM_OBJECT) begin
                d = 16 * ga;
                r[0] = volt_to_code(10 * gx - 16 * longint'(cfg_ch), d);
                r[1] = volt_to_code(10 * gy - 16 * longint'(cfg_cv), d);
            end else begin
                return 0;
            end
            r[2] = volt_to_code(10 * ps + 16 * pa * longint'(cfg_pofs), 160 * pa);
            if (orat > OPEN_LIMIT) orat = OPEN_LIMIT;
            r[3] = (orat * CMAX) / 1024 + CMID;
        end
        if (halve) for (int i = 0; i < 4; i++) r[i] = (r[i] >>> 1) + HBIAS;
        c.h = r[0][15:0];
        c.v = r[1][15:0];
        c.p = r[2][15:0];
        c.o = r[3][15:0];
        return 1;
    endfunction

    task automatic reg_write(reg_index_t idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_GAZE_MODE:  cfg_mode = val[1:0];
            REG_CENTER_H:   cfg_ch = val[10:0];
            REG_CENTER_V:   cfg_cv = val[10:0];
            REG_GAZE_AMP:   cfg_gamp = val[6:0];
            REG_PUPIL_OFS:  cfg_pofs = val[7:0];
            REG_PUPIL_AMP:  cfg_pamp = val[6:0];
            REG_HALF_RANGE: cfg_half = val[0];
            REG_FAIL_MODE:  cfg_fail = val[1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(logic [1:0] md, int ch, int cv, int ga, int po, int pa,
                              bit hf, logic [1:0] fm);
        reg_write(REG_GAZE_MODE, 32'(md));
        reg_write(REG_CENTER_H, ch);
        reg_write(REG_CENTER_V, cv);
        reg_write(REG_GAZE_AMP, ga);
        reg_write(REG_PUPIL_OFS, po);
        reg_write(REG_PUPIL_AMP, pa);
        reg_write(REG_HALF_RANGE, 32'(hf));
        reg_write(REG_FAIL_MODE, 32'(fm));
    endtask

    task automatic drain_pipe();
        s_valid <= 0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (LAT + 4) @(posedge aclk);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_sample(bit sv, logic [15:0] gx, logic [15:0] gy, logic [15:0] ps,
                               logic [9:0] orat, logic [11:0] iw, logic [11:0] ih,
                               bit gaps);
        codes_t c;
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1;
        s_sample_valid <= sv;
        s_gaze_x <= gx;
        s_gaze_y <= gy;
        s_pupil_size <= ps;
        s_open_ratio <= orat;
        s_image_width <= iw;
        s_image_height <= ih;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_codes(sv, $signed(gx), $signed(gy), ps, orat, iw, ih, c))
            expected_codes = {expected_codes, c};
        n_items++;
    endtask

    task automatic send_random(bit well_formed);
        logic [15:0] gx, gy;
        logic [11:0] iw, ih;
        gx = 16'($urandom);
        gy = 16'($urandom);
        iw = 12'($urandom);
        ih = 12'($urandom);
        if (well_formed) begin
            iw = 12'($urandom_range(160, 1920));
            ih = 12'($urandom_range(120, 1080));
            gx = (cfg_mode == GM_PIXEL) ? 16'($urandom_range(0, iw * 16))
                                        : 16'($signed($urandom_range(0, 1600)) - 800);
            gy = (cfg_mode == GM_PIXEL) ? 16'($urandom_range(0, ih * 16))
                                        : 16'($signed($urandom_range(0, 1600)) - 800);
        end
        send_sample($urandom_range(0, 9) != 0, gx, gy, 16'($urandom), 10'($urandom),
                    iw, ih, 1);
    endtask

    task automatic test_defaults();
        send_sample(1, 16'h0000, 16'h0000, 0, 0, 640, 480, 0);
        send_sample(1, 16'h7fff, 16'h8000, 16'hffff, 10'h3ff, 12'hfff, 12'hfff, 0);
        send_sample(1, 16'h8000, 16'h7fff, 0, 512, 0, 0, 0);
        send_sample(0, 16'h1234, 16'h5678, 100, 100, 100, 100, 0);
        drain_pipe();
    endtask

    task automatic test_modes_and_failures();
        for (int fm = 0; fm < 4; fm++) begin
            set_config(2'(fm % 3), -900, 1000, 1, -100, 1, fm[0], 2'(fm));
            send_sample(0, 0, 0, 0, 0, 0, 0, 0);
            send_sample(1, 16'h7fff, 16'h8000, 16'hffff, 513, 12'hfff, 1, 0);
            send_sample(1, 16'h8000, 16'h7fff, 0, 511, 1, 12'hfff, 0);
            drain_pipe();
        end
        set_config(GM_RESERVED, 0, 0, 0, 100, 0, 0, FM_MID);
        send_sample(1, 5, 5, 5, 5, 5, 5, 0);
        send_sample(0, 5, 5, 5, 5, 5, 5, 0);
        drain_pipe();
        set_config(GM_CAMERA, 1000, -900, 100, 127, 100, 1, FM_MAX);
        send_sample(1, 16'h7fff, 16'h8000, 16'hffff, 10'h3ff, 0, 0, 0);
        send_sample(1, 0, 0, 0, 0, 0, 0, 0);
        drain_pipe();
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        for (int i = 0; i < 60; i++) send_random(1);
        drain_pipe();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 9; phase++) begin
            set_config(2'($urandom_range(0, 3)), $signed($urandom_range(0, 1900)) - 900,
                       $signed($urandom_range(0, 1900)) - 900, $urandom_range(0, 127),
                       $urandom_range(0, 255), $urandom_range(0, 127),
                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            rx_idle_off = (phase == 4);
            for (int i = 0; i < 100; i++) send_random($urandom_range(0, 3) != 0);
            drain_pipe();
        end
        rx_idle_off = 0;
    endtask

    always @(posedge aclk) begin
        int g;
        if (hold_off) begin
            m_ready <= 0;
            repeat (200) @(posedge aclk);
            hold_off = 0;
        end else if (rx_idle_off) begin
            m_ready <= 1;
        end else begin
            g = gap_len();
            m_ready <= (g == 0);
        end
    end

    always @(posedge aclk) begin
        codes_t c;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_codes.size() == 0) begin
                $display("%0t: unexpected result h=%h v=%h p=%h o=%h", $time,
                         m_code_h, m_code_v, m_code_pupil, m_code_open);
                errors++;
            end else begin
                c = expected_codes.pop_front();
                if (m_code_h !== c.h) begin
                    $display("%0t: code_h expected %h actual %h", $time, c.h, m_code_h);
                    errors++;
                end
                if (m_code_v !== c.v) begin
                    $display("%0t: code_v expected %h actual %h", $time, c.v, m_code_v);
                    errors++;
                end
                if (m_code_pupil !== c.p) begin
                    $display("%0t: code_pupil expected %h actual %h", $time, c.p,
                             m_code_pupil);
                    errors++;
                end
                if (m_code_open !== c.o) begin
                    $display("%0t: code_open expected %h actual %h", $time, c.o,
                             m_code_open);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("gaze_to_dac_code_mapper: mismatch");
        $finish;
    end

    initial begin
        cfg_mode = GM_PIXEL;
        cfg_ch = 500;
        cfg_cv = 500;
        cfg_gamp = 10;
        cfg_pofs = 0;
        cfg_pamp = 10;
        cfg_half = 0;
        cfg_fail = FM_HOLD;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_defaults();
        test_modes_and_failures();
        test_backpressure();
        test_random();
        drain_pipe();
        if (expected_codes.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_codes.size());
            errors++;
        end
        $display("Sent %0d samples over all gaze and failure modes, got %0d code sets.",
                 n_items, n_results);
        if (errors == 0) $display("gaze_to_dac_code_mapper: match");
        else $display("gaze_to_dac_code_mapper: mismatch");
        $finish;
    end
endmodule
